@@ rtl/m3inv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants and types for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int ELEM_BITS_DEF = 32;
    localparam int FRAC_BITS     = 16;

    // per-element divider control, travels with the request
    typedef struct packed {
        logic neg;
        logic zero;
    } div_ctl_t;

    // per-element divider status
    typedef struct packed {
        logic sat;
        logic zero;
    } div_flag_t;

endpackage

@@ rtl/m3inv_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_div
// Pipelined restoring divider: trunc(num * 2^(2F) / den) on magnitudes,
// one quotient bit per stage, signed and saturated to ELEM_BITS at the end.
// ----------------------------------------------------------------------------
module m3inv_div #(
    parameter int ELEM_BITS = m3inv_pkg::ELEM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [2*ELEM_BITS-1:0]        num_i,
    input  logic [3*ELEM_BITS-1:0]        den_i,
    input  m3inv_pkg::div_ctl_t           ctl_i,
    output logic signed [ELEM_BITS-1:0]   quo_o,
    output m3inv_pkg::div_flag_t          flg_o
);

    localparam int EB = ELEM_BITS;
    localparam int FB = m3inv_pkg::FRAC_BITS;
    localparam int NW = 2*EB + 2*FB;
    localparam int DW = 3*EB;
    localparam int CW = (NW > DW + EB) ? NW + 1 : DW + EB + 1;

    logic [NW-1:0]           r_reg   [EB+1];
    logic [NW-1:0]           r_next  [EB+1];
    logic [DW-1:0]           d_reg   [EB+1];
    logic [DW-1:0]           d_next  [EB+1];
    logic                    ovf_reg [EB+1];
    logic                    ovf_next[EB+1];
    m3inv_pkg::div_ctl_t     ctl_reg [EB+1];
    m3inv_pkg::div_ctl_t     ctl_next[EB+1];
    logic [EB-1:0]           q_reg   [EB];
    logic [EB-1:0]           q_next  [EB];

    logic signed [EB-1:0]    quo_reg;
    logic signed [EB-1:0]    quo_next;
    m3inv_pkg::div_flag_t    flg_reg;
    m3inv_pkg::div_flag_t    flg_next;

    always_comb begin
        logic [CW-1:0] dsh;
        logic [CW-1:0] rx;
        logic [CW-1:0] diff;
        logic          ge;
        logic [EB-1:0] qin;
        logic [EB-1:0] mag;
        logic [EB-1:0] lim;
        logic [EB-1:0] sel;
        logic          sat;

        // entry stage: scale numerator, catch quotients of 2^EB or more
        r_next[0]   = {num_i, {(2*FB){1'b0}}};
        d_next[0]   = den_i;
        ovf_next[0] = CW'({num_i, {(2*FB){1'b0}}}) >= (CW'(den_i) << EB);
        ctl_next[0] = ctl_i;

        for (int s = 1; s <= EB; s++) begin
            dsh  = CW'(d_reg[s-1]) << (EB - s);
            rx   = CW'(r_reg[s-1]);
            diff = rx - dsh;
            ge   = (rx >= dsh);
            qin  = (s == 1) ? '0 : q_reg[(s >= 2) ? s - 2 : 0];
            r_next[s]   = ge ? diff[NW-1:0] : r_reg[s-1];
            q_next[s-1] = qin | (ge ? (EB'(1) << (EB - s)) : '0);
            d_next[s]   = d_reg[s-1];
            ovf_next[s] = ovf_reg[s-1];
            ctl_next[s] = ctl_reg[s-1];
        end

        mag = q_reg[EB-1];
        lim = ctl_reg[EB].neg ? (EB'(1) << (EB - 1)) : ((EB'(1) << (EB - 1)) - EB'(1));
        sat = ovf_reg[EB] | (mag > lim);
        sel = sat ? lim : mag;
        if (ctl_reg[EB].zero) begin
            quo_next      = '0;
            flg_next.sat  = 1'b0;
            flg_next.zero = 1'b1;
        end else begin
            quo_next      = ctl_reg[EB].neg ? (~sel + 1'b1) : sel;
            flg_next.sat  = sat;
            flg_next.zero = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= EB; s++) begin
                r_reg[s]   <= r_next[s];
                d_reg[s]   <= d_next[s];
                ovf_reg[s] <= ovf_next[s];
                ctl_reg[s] <= ctl_next[s];
            end
            for (int s = 0; s < EB; s++) begin
                q_reg[s] <= q_next[s];
            end
            quo_reg <= quo_next;
            flg_reg <= flg_next;
        end
    end

    assign quo_o = quo_reg;
    assign flg_o = flg_reg;

endmodule

@@ rtl/matrix3_inverse_core.sv @@
`timescale 1ns / 1ps
// throughput: one matrix per cycle while no result is stalled; ten stages form
// cofactors and determinant, then one divider stage per quotient bit sets the depth
// a stalled result freezes the whole pipeline, nothing is dropped
// reset clears only the stage valid bits; datapath registers are not reset
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// 3x3 Q16.16 matrix inverse by adjugate: exact cofactors and determinant,
// then nine pipelined dividers with truncation and saturation.
// ----------------------------------------------------------------------------
module matrix3_inverse_core #(
    parameter int ELEM_BITS = m3inv_pkg::ELEM_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [ELEM_BITS-1:0] s_in_r0c0,
    input  logic signed [ELEM_BITS-1:0] s_in_r0c1,
    input  logic signed [ELEM_BITS-1:0] s_in_r0c2,
    input  logic signed [ELEM_BITS-1:0] s_in_r1c0,
    input  logic signed [ELEM_BITS-1:0] s_in_r1c1,
    input  logic signed [ELEM_BITS-1:0] s_in_r1c2,
    input  logic signed [ELEM_BITS-1:0] s_in_r2c0,
    input  logic signed [ELEM_BITS-1:0] s_in_r2c1,
    input  logic signed [ELEM_BITS-1:0] s_in_r2c2,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [ELEM_BITS-1:0] m_out_r0c0,
    output logic signed [ELEM_BITS-1:0] m_out_r0c1,
    output logic signed [ELEM_BITS-1:0] m_out_r0c2,
    output logic signed [ELEM_BITS-1:0] m_out_r1c0,
    output logic signed [ELEM_BITS-1:0] m_out_r1c1,
    output logic signed [ELEM_BITS-1:0] m_out_r1c2,
    output logic signed [ELEM_BITS-1:0] m_out_r2c0,
    output logic signed [ELEM_BITS-1:0] m_out_r2c1,
    output logic signed [ELEM_BITS-1:0] m_out_r2c2,
    output logic                        m_singular,
    output logic                        m_overflow
);

    localparam int EB   = ELEM_BITS;
    localparam int K    = (EB + 1) / 2;
    localparam int PW   = 2*EB;
    localparam int CFW  = 2*EB + 1;
    localparam int DPW  = 3*EB;
    localparam int DTW  = 3*EB + 1;
    localparam int PIPE = EB + 12;

    logic en;
    logic vld_reg  [PIPE];
    logic vld_next [PIPE];

    // stage 0: captured request
    logic signed [EB-1:0]  e_reg     [9];
    logic signed [EB-1:0]  e_next    [9];
    // stage 1: magnitudes
    logic [EB-1:0]         emag_reg  [9];
    logic [EB-1:0]         emag_next [9];
    logic                  esgn_reg  [9];
    logic                  esgn_next [9];
    // stage 2: cofactor partial products
    logic [2*K-1:0]        pp_reg    [9][2][4];
    logic [2*K-1:0]        pp_next   [9][2][4];
    logic                  psg_reg   [9][2];
    logic                  psg_next  [9][2];
    // row 0 carried through stages 2..5
    logic [EB-1:0]         r0m_reg   [4][3];
    logic [EB-1:0]         r0m_next  [4][3];
    logic                  r0s_reg   [4][3];
    logic                  r0s_next  [4][3];
    // stage 3: signed products
    logic [CFW-1:0]        ps_reg    [9][2];
    logic [CFW-1:0]        ps_next   [9][2];
    // stage 4: cofactors
    logic signed [CFW-1:0] cof_reg   [9];
    logic signed [CFW-1:0] cof_next  [9];
    // stage 5: cofactor magnitudes
    logic [PW-1:0]         cmag_reg  [9];
    logic [PW-1:0]         cmag_next [9];
    logic                  csgn_reg  [9];
    logic                  csgn_next [9];
    // cofactors carried through stages 6..9
    logic [PW-1:0]         cmd_reg   [4][9];
    logic [PW-1:0]         cmd_next  [4][9];
    logic                  csd_reg   [4][9];
    logic                  csd_next  [4][9];
    // stage 6: determinant partial products
    logic [2*K-1:0]        dpp_reg   [3][8];
    logic [2*K-1:0]        dpp_next  [3][8];
    logic                  dsg_reg   [3];
    logic                  dsg_next  [3];
    // stage 7: signed row-0 terms
    logic [DTW-1:0]        dp_reg    [3];
    logic [DTW-1:0]        dp_next   [3];
    // stage 8: determinant
    logic signed [DTW-1:0] det_reg;
    logic signed [DTW-1:0] det_next;
    // stage 9: determinant magnitude
    logic [DPW-1:0]        dmag_reg;
    logic [DPW-1:0]        dmag_next;
    logic                  dsgn_reg;
    logic                  dsgn_next;
    logic                  dzero_reg;
    logic                  dzero_next;

    logic signed [EB-1:0]  quo  [9];
    m3inv_pkg::div_flag_t  flg  [9];

    assign en      = !vld_reg[PIPE-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE-1];

    always_comb begin
        vld_next[0] = s_valid;
        for (int s = 1; s < PIPE; s++) begin
            vld_next[s] = vld_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < PIPE; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < PIPE; s++) begin
                vld_reg[s] <= vld_next[s];
            end
        end
    end

    // cofactor and determinant datapath
    always_comb begin
        int             r, c, r1, r2, c1, c2, x, y;
        logic [2*K-1:0] xa;
        logic [2*K-1:0] xb;
        logic [4*K-1:0] xc;
        logic [4*K-1:0] pm;
        logic [6*K-1:0] acc;
        logic [CFW-1:0] mx;
        logic [DTW-1:0] dx;
        logic [CFW-1:0] cneg;
        logic [DTW-1:0] dneg;

        e_next[0] = s_in_r0c0;
        e_next[1] = s_in_r0c1;
        e_next[2] = s_in_r0c2;
        e_next[3] = s_in_r1c0;
        e_next[4] = s_in_r1c1;
        e_next[5] = s_in_r1c2;
        e_next[6] = s_in_r2c0;
        e_next[7] = s_in_r2c1;
        e_next[8] = s_in_r2c2;

        for (int i = 0; i < 9; i++) begin
            esgn_next[i] = e_reg[i][EB-1];
            emag_next[i] = e_reg[i][EB-1] ? (~e_reg[i] + 1'b1) : e_reg[i];
        end

        // two element products per cofactor, 2x2 half-width partials each
        for (int k = 0; k < 9; k++) begin
            r  = k / 3;
            c  = k % 3;
            r1 = (r + 1) % 3;
            r2 = (r + 2) % 3;
            c1 = (c + 1) % 3;
            c2 = (c + 2) % 3;
            for (int t = 0; t < 2; t++) begin
                x  = r1*3 + ((t == 0) ? c1 : c2);
                y  = r2*3 + ((t == 0) ? c2 : c1);
                xa = (2*K)'(emag_reg[x]);
                xb = (2*K)'(emag_reg[y]);
                for (int i = 0; i < 2; i++) begin
                    for (int j = 0; j < 2; j++) begin
                        pp_next[k][t][i*2+j] = (2*K)'(xa[i*K +: K] * xb[j*K +: K]);
                    end
                end
                psg_next[k][t] = esgn_reg[x] ^ esgn_reg[y];
            end
        end

        for (int j = 0; j < 3; j++) begin
            r0m_next[0][j] = emag_reg[j];
            r0s_next[0][j] = esgn_reg[j];
            for (int s = 1; s < 4; s++) begin
                r0m_next[s][j] = r0m_reg[s-1][j];
                r0s_next[s][j] = r0s_reg[s-1][j];
            end
        end

        for (int k = 0; k < 9; k++) begin
            for (int t = 0; t < 2; t++) begin
                pm = (4*K)'(pp_reg[k][t][0])
                   + ((4*K)'(pp_reg[k][t][1]) << K)
                   + ((4*K)'(pp_reg[k][t][2]) << K)
                   + ((4*K)'(pp_reg[k][t][3]) << (2*K));
                mx = {1'b0, pm[PW-1:0]};
                ps_next[k][t] = psg_reg[k][t] ? (~mx + 1'b1) : mx;
            end
            cof_next[k]  = $signed(ps_reg[k][0]) - $signed(ps_reg[k][1]);
            cneg         = ~cof_reg[k] + 1'b1;
            csgn_next[k] = cof_reg[k][CFW-1];
            cmag_next[k] = cof_reg[k][CFW-1] ? cneg[PW-1:0] : cof_reg[k][PW-1:0];
            cmd_next[0][k] = cmag_reg[k];
            csd_next[0][k] = csgn_reg[k];
            for (int s = 1; s < 4; s++) begin
                cmd_next[s][k] = cmd_reg[s-1][k];
                csd_next[s][k] = csd_reg[s-1][k];
            end
        end

        // row-0 expansion: element (2 chunks) times cofactor (4 chunks)
        for (int j = 0; j < 3; j++) begin
            xa = (2*K)'(r0m_reg[3][j]);
            xc = (4*K)'(cmag_reg[j]);
            for (int i = 0; i < 2; i++) begin
                for (int m = 0; m < 4; m++) begin
                    dpp_next[j][i*4+m] = (2*K)'(xa[i*K +: K] * xc[m*K +: K]);
                end
            end
            dsg_next[j] = r0s_reg[3][j] ^ csgn_reg[j];

            acc = '0;
            for (int i = 0; i < 2; i++) begin
                for (int m = 0; m < 4; m++) begin
                    acc = acc + ((6*K)'(dpp_reg[j][i*4+m]) << ((i + m)*K));
                end
            end
            dx = {1'b0, acc[DPW-1:0]};
            dp_next[j] = dsg_reg[j] ? (~dx + 1'b1) : dx;
        end

        det_next   = $signed(dp_reg[0]) + $signed(dp_reg[1]) + $signed(dp_reg[2]);
        dneg       = ~det_reg + 1'b1;
        dsgn_next  = det_reg[DTW-1];
        dmag_next  = det_reg[DTW-1] ? dneg[DPW-1:0] : det_reg[DPW-1:0];
        dzero_next = (det_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg     <= e_next;
            emag_reg  <= emag_next;
            esgn_reg  <= esgn_next;
            pp_reg    <= pp_next;
            psg_reg   <= psg_next;
            r0m_reg   <= r0m_next;
            r0s_reg   <= r0s_next;
            ps_reg    <= ps_next;
            cof_reg   <= cof_next;
            cmag_reg  <= cmag_next;
            csgn_reg  <= csgn_next;
            cmd_reg   <= cmd_next;
            csd_reg   <= csd_next;
            dpp_reg   <= dpp_next;
            dsg_reg   <= dsg_next;
            dp_reg    <= dp_next;
            det_reg   <= det_next;
            dmag_reg  <= dmag_next;
            dsgn_reg  <= dsgn_next;
            dzero_reg <= dzero_next;
        end
    end

    // inverse (i,j) takes the cofactor of element (j,i)
    for (genvar o = 0; o < 9; o++) begin : g_div
        localparam int SRC = (o % 3)*3 + (o / 3);
        m3inv_pkg::div_ctl_t ctl;

        assign ctl.neg  = csd_reg[3][SRC] ^ dsgn_reg;
        assign ctl.zero = dzero_reg;

        m3inv_div #(
            .ELEM_BITS (ELEM_BITS)
        ) u_div (
            .aclk  (aclk),
            .en    (en),
            .num_i (cmd_reg[3][SRC]),
            .den_i (dmag_reg),
            .ctl_i (ctl),
            .quo_o (quo[o]),
            .flg_o (flg[o])
        );
    end

    assign m_out_r0c0 = quo[0];
    assign m_out_r0c1 = quo[1];
    assign m_out_r0c2 = quo[2];
    assign m_out_r1c0 = quo[3];
    assign m_out_r1c1 = quo[4];
    assign m_out_r1c2 = quo[5];
    assign m_out_r2c0 = quo[6];
    assign m_out_r2c1 = quo[7];
    assign m_out_r2c2 = quo[8];

    assign m_singular = flg[0].zero;
    assign m_overflow = flg[0].sat | flg[1].sat | flg[2].sat | flg[3].sat | flg[4].sat
                      | flg[5].sat | flg[6].sat | flg[7].sat | flg[8].sat;

endmodule

@@ dv/tb_matrix3_inverse_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3_inverse_core
// Self-checking bench for the 3x3 Q16.16 adjugate inverse. Matrices are sent
// with random bursts and gaps, results are drained under a random stall
// pattern, and every result is compared with an exact wide-integer inverse.
// ----------------------------------------------------------------------------
module tb_matrix3_inverse_core;

    localparam int EB = m3inv_pkg::ELEM_BITS_DEF;
    localparam int FB = m3inv_pkg::FRAC_BITS;
    localparam int LAT = EB + 12;
    localparam int N_RANDOM = 1530;

    typedef logic signed [EB-1:0] elem_t;
    typedef struct {
        elem_t e[9];
        logic  singular;
        logic  overflow;
    } inverse_t;

    int errors = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        errors++;
    endtask

    // exact inverse: cofactors and determinant in 200-bit signed arithmetic
    function automatic inverse_t compute_inverse(input elem_t m[9]);
        inverse_t r;
        logic signed [199:0] a[3][3];
        logic signed [199:0] cof[3][3];
        logic signed [199:0] det, num, q, lim_hi, lim_lo;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = m[i*3+j];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                          - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
        det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
        r.singular = (det == 0);
        r.overflow = 0;
        lim_hi = (200'sd1 <<< (EB-1)) - 1;
        lim_lo = -(200'sd1 <<< (EB-1));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                if (r.singular) begin
                    r.e[i*3+j] = '0;
                end else begin
                    num = cof[j][i] <<< (2*FB);
                    q = num / det;  // signed divide truncates toward zero
                    if (q > lim_hi) begin
                        q = lim_hi;
                        r.overflow = 1;
                    end else if (q < lim_lo) begin
                        q = lim_lo;
                        r.overflow = 1;
                    end
                    r.e[i*3+j] = q[EB-1:0];
                end
            end
        return r;
    endfunction

    class inverse_scoreboard;
        inverse_t pending[$];
        int       n_checked;
        int       n_singular;
        int       n_overflow;

        function void note_request(elem_t m[9]);
            pending.push_back(compute_inverse(m));
        endfunction

        task check_result(inverse_t got);
            inverse_t want;
            if (pending.size() == 0) begin
                report("result with nothing pending", 0, 0);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (want.singular) n_singular++;
            if (want.overflow) n_overflow++;
            for (int k = 0; k < 9; k++)
                if (got.e[k] !== want.e[k])
                    report($sformatf("element %0d", k), got.e[k], want.e[k]);
            if (got.singular !== want.singular)
                report("singular", got.singular, want.singular);
            if (got.overflow !== want.overflow)
                report("overflow", got.overflow, want.overflow);
        endtask
    endclass

    logic  aclk = 0;
    logic  aresetn = 0;
    logic  s_valid = 0;
    logic  s_ready;
    elem_t s_m[9];
    logic  m_valid;
    logic  m_ready = 0;
    elem_t m_m[9];
    logic  m_singular, m_overflow;
    logic  hold_off = 0;

    inverse_scoreboard sb = new();

    always #5 aclk = ~aclk;

    initial begin
        for (int k = 0; k < 9; k++) s_m[k] = '0;
    end

    matrix3_inverse_core #(.ELEM_BITS(EB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_r0c0(s_m[0]), .s_in_r0c1(s_m[1]), .s_in_r0c2(s_m[2]),
        .s_in_r1c0(s_m[3]), .s_in_r1c1(s_m[4]), .s_in_r1c2(s_m[5]),
        .s_in_r2c0(s_m[6]), .s_in_r2c1(s_m[7]), .s_in_r2c2(s_m[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_r0c0(m_m[0]), .m_out_r0c1(m_m[1]), .m_out_r0c2(m_m[2]),
        .m_out_r1c0(m_m[3]), .m_out_r1c1(m_m[4]), .m_out_r1c2(m_m[5]),
        .m_out_r2c0(m_m[6]), .m_out_r2c1(m_m[7]), .m_out_r2c2(m_m[8]),
        .m_singular(m_singular), .m_overflow(m_overflow)
    );

    // note requests and check results at the clock edge
    always @(posedge aclk) begin
        inverse_t got;
        if (aresetn && s_valid && s_ready) sb.note_request(s_m);
        if (aresetn && m_valid && m_ready) begin
            for (int k = 0; k < 9; k++) got.e[k] = m_m[k];
            got.singular = m_singular;
            got.overflow = m_overflow;
            sb.check_result(got);
        end
    end

    // receiver: stall pattern, fully open stretches, and long hold-offs
    initial begin
        int mode;
        @(posedge aclk iff aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(10, 60)) begin
                @(posedge aclk);
                if (hold_off) m_ready <= 0;
                else if (mode == 0) m_ready <= 1;
                else if (mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
                else if (mode == 2) m_ready <= ($urandom_range(0, 3) == 0);
                else m_ready <= ~m_ready;
            end
        end
    end

    function automatic elem_t rand_elem(input int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2: return elem_t'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom_range(0, 1) ? {1'b0, {(EB-1){1'b1}}}
                                                 : {1'b1, {(EB-1){1'b0}}};
        endcase
    endfunction

    task automatic send_matrix(input elem_t m[9]);
        s_valid <= 1;
        for (int k = 0; k < 9; k++) s_m[k] <= m[k];
        @(posedge aclk iff s_ready);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 0;
        repeat (cycles) @(posedge aclk);
    endtask

    // the first edge lets the last request reach the scoreboard
    task automatic drain_results();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // directed matrices, then random bursts of random matrices
    initial begin
        elem_t m[9];
        elem_t one, emax, emin;
        int kind, burst;
        one  = 1 << FB;
        emax = {1'b0, {(EB-1){1'b1}}};
        emin = {1'b1, {(EB-1){1'b0}}};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        for (int t = 0; t < 20; t++) begin
            for (int k = 0; k < 9; k++) m[k] = 0;
            case (t)
                0: begin m[0] = one; m[4] = one; m[8] = one; end     // identity
                1: ;                                                  // all zero
                2: for (int k = 0; k < 9; k++) m[k] = emax;          // singular
                3: begin m[0] = emin; m[4] = emin; m[8] = emin; end
                4: begin m[0] = emax; m[4] = emax; m[8] = emax; end
                5: begin m[0] = 1; m[4] = 1; m[8] = 1; end            // saturates
                6: begin m[0] = -1; m[4] = 1; m[8] = -1; end
                7: begin m[0] = 2*one; m[4] = -4*one; m[8] = one/2; end
                8: begin m[2] = one; m[4] = one; m[6] = one; end     // permutation
                9: begin m[0] = emin; m[4] = emax; m[8] = emin; m[1] = emax; end
                10: for (int k = 0; k < 9; k++) m[k] = (k % 2) ? emin : emax;
                11: for (int k = 0; k < 9; k++) m[k] = -1;
                12: begin m[0] = 3*one; m[1] = one; m[3] = one; m[4] = 3*one;
                          m[8] = -one; end
                13: begin m[0] = one; m[1] = 2*one; m[3] = 2*one; m[4] = 4*one;
                          m[8] = one; end                             // rank 2
                default: for (int k = 0; k < 9; k++) m[k] = rand_elem(t % 4);
            endcase
            send_matrix(m);
        end
        drain_results();

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                kind = $urandom_range(0, 9);
                for (int k = 0; k < 9; k++)
                    m[k] = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
                if ($urandom_range(0, 15) == 0) begin
                    for (int k = 0; k < 3; k++) m[6+k] = m[3+k];   // duplicate row
                end
                send_matrix(m);
            end
            if (n > 400 && n < 450 && !hold_off) begin
                // long receiver hold-off while requests keep coming
                hold_off = 1;
                fork
                    begin repeat (3 * LAT) @(posedge aclk); hold_off = 0; end
                join_none
            end else if (n > 900 && n < 950) begin
                drain_results();
            end else if ($urandom_range(0, 2) != 0) begin
                pause_sender($urandom_range(1, 30));
            end
        end
        drain_results();
        repeat (LAT + 10) @(posedge aclk);
        $display("covered %0d matrices: %0d singular, %0d with saturation",
                 sb.n_checked, sb.n_singular, sb.n_overflow);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ matrix3_inverse_core.f @@
rtl/m3inv_pkg.sv
rtl/m3inv_div.sv
rtl/matrix3_inverse_core.sv
dv/tb_matrix3_inverse_core.sv
